FILE: sv/pf_pkg.sv
// Package with the shared types, constants and helpers of the Playfair digraph encryptor.
package pf_pkg;

    // Geometry of the key square and widths of its codes.
    localparam int unsigned SQ_DIM = 5;
    localparam int unsigned CODE_W = 5;
    localparam int unsigned ROW_W  = SQ_DIM * CODE_W;
    localparam int unsigned IDX_W  = 3;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef row_t [SQ_DIM-1:0] square_t;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_ROW_ZERO  = 3'd0,
        REG_ROW_ONE   = 3'd1,
        REG_ROW_TWO   = 3'd2,
        REG_ROW_THREE = 3'd3,
        REG_ROW_FOUR  = 3'd4
    } reg_idx_t;

    // Position of a letter in the square, with a flag for a hit.
    typedef struct packed {
        logic found;
        idx_t row;
        idx_t col;
    } pos_t;

    // Letter code held at a given row and column of the square.
    function automatic code_t cell_at(square_t sq, idx_t r, idx_t c);
        return sq[r][CODE_W*int'(c) +: CODE_W];
    endfunction

    // Step one place along a row or column, wrapping at the edge.
    function automatic idx_t wrap_inc(idx_t i);
        return (i == idx_t'(SQ_DIM - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

endpackage

FILE: sv/playfair_digraph_encrypt.sv
// Top level of the Playfair digraph encryptor: key square, input and result registers.
//
// One digraph is taken at every clock edge at which start is high; busy is
// never raised, so a transaction may be offered in every cycle. The letters
// are captured in an input register, located in the key square and enciphered
// in the following cycle, and the result is registered: done pulses for one
// cycle once the result register is loaded, with first_cipher, second_cipher
// and letter_missing valid alongside it. The receiver cannot stall, so each
// result must be taken in the cycle it is shown. The square rows are written
// through cfg_write, cfg_index and cfg_data, by the user only while no transaction
// is in flight; the block does not enforce this. An index above four is ignored.
module playfair_digraph_encrypt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pf_pkg::CODE_W-1:0]    first_letter,
    input  logic [pf_pkg::CODE_W-1:0]    second_letter,
    output logic                         done,
    output logic [pf_pkg::CODE_W-1:0]    first_cipher,
    output logic [pf_pkg::CODE_W-1:0]    second_cipher,
    output logic                         letter_missing,
    input  logic                         cfg_write,
    input  logic [pf_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pf_pkg::ROW_W-1:0]     cfg_data
);

    pf_pkg::square_t square_reg;
    logic            in_valid_reg;
    pf_pkg::code_t   first_reg;
    pf_pkg::code_t   second_reg;
    logic            done_reg;
    pf_pkg::code_t   first_cipher_reg;
    pf_pkg::code_t   second_cipher_reg;
    logic            missing_reg;

    pf_pkg::pos_t    pos_a;
    pf_pkg::pos_t    pos_b;
    pf_pkg::code_t   first_cipher_next;
    pf_pkg::code_t   second_cipher_next;
    logic            missing_next;

    // The pipeline never holds off a new transaction.
    assign busy = 1'b0;

    // Key square rows, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pf_pkg::REG_ROW_ZERO:  square_reg[0] <= cfg_data;
                pf_pkg::REG_ROW_ONE:   square_reg[1] <= cfg_data;
                pf_pkg::REG_ROW_TWO:   square_reg[2] <= cfg_data;
                pf_pkg::REG_ROW_THREE: square_reg[3] <= cfg_data;
                pf_pkg::REG_ROW_FOUR:  square_reg[4] <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            first_reg  <= first_letter;
            second_reg <= second_letter;
        end
    end

    // Locate both letters in the square.
    pf_locate u_locate_a
    (
        .square (square_reg),
        .code   (first_reg),
        .pos    (pos_a)
    );

    pf_locate u_locate_b
    (
        .square (square_reg),
        .code   (second_reg),
        .pos    (pos_b)
    );

    // Apply the substitution rules.
    pf_encode u_encode
    (
        .square   (square_reg),
        .pos_a    (pos_a),
        .pos_b    (pos_b),
        .cipher_a (first_cipher_next),
        .cipher_b (second_cipher_next),
        .missing  (missing_next)
    );

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            first_cipher_reg  <= first_cipher_next;
            second_cipher_reg <= second_cipher_next;
            missing_reg       <= missing_next;
        end
    end

    assign done           = done_reg;
    assign first_cipher   = first_cipher_reg;
    assign second_cipher  = second_cipher_reg;
    assign letter_missing = missing_reg;

    // An accepted transaction always reaches the input register.
    assert property (@(posedge clk) disable iff (!rst_n) start |=> in_valid_reg)
        else $error("accepted transaction did not reach the input register");

    // Every result strobe follows a transaction held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(in_valid_reg))
        else $error("result strobe without a transaction in the input register");

    // A pair whose letters were both found never reports a missing letter.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (in_valid_reg && pos_a.found && pos_b.found) |=> !letter_missing)
        else $error("missing flag raised for a pair that was found");

endmodule

FILE: sv/pf_locate.sv
// Parallel search of the key square for one letter code.
module pf_locate
(
    input  pf_pkg::square_t square,
    input  pf_pkg::code_t   code,
    output pf_pkg::pos_t    pos
);

    // Compare against all cells; the last match in row-major order wins.
    // A letter that is not found stays at row 0, column 0.
    always_comb
    begin
        pos = '0;
        for (int r = 0; r < int'(pf_pkg::SQ_DIM); r++)
        begin
            for (int c = 0; c < int'(pf_pkg::SQ_DIM); c++)
            begin
                if (pf_pkg::cell_at(square, pf_pkg::idx_t'(r), pf_pkg::idx_t'(c)) == code)
                begin
                    pos.found = 1'b1;
                    pos.row   = pf_pkg::idx_t'(r);
                    pos.col   = pf_pkg::idx_t'(c);
                end
            end
        end
    end

endmodule

FILE: sv/pf_encode.sv
// Playfair substitution rules applied to two located letters.
module pf_encode
(
    input  pf_pkg::square_t square,
    input  pf_pkg::pos_t    pos_a,
    input  pf_pkg::pos_t    pos_b,
    output pf_pkg::code_t   cipher_a,
    output pf_pkg::code_t   cipher_b,
    output logic            missing
);

    // Same row shifts right, same column shifts down, otherwise the
    // rectangle corners are swapped. The row test takes precedence.
    always_comb
    begin
        if (pos_a.row == pos_b.row)
        begin
            cipher_a = pf_pkg::cell_at(square, pos_a.row, pf_pkg::wrap_inc(pos_a.col));
            cipher_b = pf_pkg::cell_at(square, pos_b.row, pf_pkg::wrap_inc(pos_b.col));
        end
        else if (pos_a.col == pos_b.col)
        begin
            cipher_a = pf_pkg::cell_at(square, pf_pkg::wrap_inc(pos_a.row), pos_a.col);
            cipher_b = pf_pkg::cell_at(square, pf_pkg::wrap_inc(pos_b.row), pos_b.col);
        end
        else
        begin
            cipher_a = pf_pkg::cell_at(square, pos_a.row, pos_b.col);
            cipher_b = pf_pkg::cell_at(square, pos_b.row, pos_a.col);
        end
    end

    // Flag a pair in which either letter has no cell in the square.
    assign missing = !(pos_a.found && pos_b.found);

endmodule
